FILE: rtl/core/bds_pkg.sv
// Package for the 2x2 box downsampler: widths, register indexes and reset values.
// Used by the stream interfaces and the top level.
`default_nettype none

package bds_pkg;

    // Sample and channel geometry.
    localparam int PIX_W  = 8;
    localparam int NUM_CH = 4;
    localparam int PAIR_W = PIX_W + 1;
    localparam int SUM_W  = PIX_W + 2;

    // Configuration port geometry.
    localparam int ROW_WIDTH_W = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = ROW_WIDTH_W;

    // Default for the widest supported row.
    localparam int DEFAULT_MAX_WIDTH = 2048;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FOUR_CHANNELS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_MODE = 2'd2;

    // Reset values and fixed levels.
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 12'd640;
    localparam logic [SUM_W-1:0]       THRESH_LEVEL    = 10'd255;
    localparam logic [PIX_W-1:0]       PIX_MAX         = 8'd255;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [PAIR_W-1:0] pair_t;
    typedef logic [SUM_W-1:0]  sum_t;

endpackage : bds_pkg

`default_nettype wire

FILE: rtl/core/bds_pix_if.sv
// Input stream interface of the box downsampler: one pixel word per handshake.
// Depends on bds_pkg for the sample width.
`default_nettype none

interface bds_pix_if;
    import bds_pkg::*;

    logic valid;
    logic ready;
    logic start_of_frame;
    pix_t in_c0;
    pix_t in_c1;
    pix_t in_c2;
    pix_t in_c3;

    modport source (output valid, output start_of_frame, output in_c0, output in_c1,
                    output in_c2, output in_c3, input ready);
    modport sink   (input valid, input start_of_frame, input in_c0, input in_c1,
                    input in_c2, input in_c3, output ready);
endinterface : bds_pix_if

`default_nettype wire

FILE: rtl/core/bds_res_if.sv
// Output stream interface of the box downsampler: one downsampled pixel word per handshake.
// Depends on bds_pkg for the sample width.
`default_nettype none

interface bds_res_if;
    import bds_pkg::*;

    logic valid;
    logic ready;
    pix_t out_c0;
    pix_t out_c1;
    pix_t out_c2;
    pix_t out_c3;
    logic row_end;

    modport source (output valid, output out_c0, output out_c1, output out_c2,
                    output out_c3, output row_end, input ready);
    modport sink   (input valid, input out_c0, input out_c1, input out_c2,
                    input out_c3, input row_end, output ready);
endinterface : bds_res_if

`default_nettype wire

FILE: rtl/core/bds_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the pair-sum line store of the box downsampler.
`default_nettype none

module bds_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while the read enable is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : bds_ram

`default_nettype wire

FILE: rtl/core/box_downsample_2x2_top.sv
// Top level of the streaming 2x2 box downsampler.
// Depends on bds_pkg, the bds_pix_if and bds_res_if interfaces and bds_ram.
`default_nettype none

// The block takes one pixel word per clock in raster order, unless stalled, and
// returns one result word for every 2x2 block, on the odd column of each odd row.
// The edge that accepts the last pixel of a block also registers the read of the
// pair-sum line store and the odd-row pair sums in stage one; the block sum is
// loaded into the result register when stage one advances. Throughput is one
// pixel per cycle while not stalled; the input stalls only while both the stage after the line
// store and the result register hold words that the sink has not taken. The
// line store needs no clearing after reset; the last column of an odd-width row
// is dropped and a trailing even row yields nothing. Change configuration only
// while idle.
module box_downsample_2x2_top #(
    parameter int MAX_WIDTH = bds_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [bds_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bds_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    bds_pix_if.sink                             pixels,
    bds_res_if.source                           results
);
    import bds_pkg::*;

    localparam int PairDepth = MAX_WIDTH / 2;
    localparam int AddrW     = $clog2(PairDepth);
    localparam int ColW      = $clog2(MAX_WIDTH);
    localparam int MaxBits   = $clog2(MAX_WIDTH + 1);
    localparam int WidW      = ((MaxBits > ROW_WIDTH_W) ? MaxBits : ROW_WIDTH_W) + 1;
    localparam int WordW     = NUM_CH * PAIR_W;

    // Configuration registers.
    logic [ROW_WIDTH_W-1:0] row_width_reg;
    logic                   four_channels_reg;
    logic                   threshold_mode_reg;

    // Position and pairing state.
    logic [ColW-1:0]              col_reg, col_next;
    logic                         odd_row_reg, odd_row_next;
    logic [NUM_CH-1:0][PIX_W-1:0] first_reg;

    // Stage between the line store read and the result register.
    logic                          s1_valid_reg;
    logic [NUM_CH-1:0][PAIR_W-1:0] s1_pair_reg;
    logic                          s1_row_end_reg;

    // Result register.
    logic                         out_valid_reg;
    logic [NUM_CH-1:0][PIX_W-1:0] out_pix_reg, out_pix_next;
    logic                         out_row_end_reg;

    logic                          accept;
    logic                          out_adv;
    logic                          s1_adv;
    logic [NUM_CH-1:0][PIX_W-1:0]  px;
    logic [NUM_CH-1:0][PAIR_W-1:0] pair;
    logic [NUM_CH-1:0][PAIR_W-1:0] stored;
    logic [WordW-1:0]              ram_rdata;
    logic [WidW-1:0]               eff_width;
    logic [WidW-1:0]               row_width_ext;
    logic [WidW-1:0]               col_ext;
    logic [WidW-1:0]               col_inc;
    logic [ColW-1:0]               col_cur;
    logic                          odd_cur;
    logic                          in_row;
    logic                          odd_col;
    logic                          row_done;
    logic                          produce;
    logic                          row_end;
    logic                          ram_we;
    logic                          ram_re;
    logic [AddrW-1:0]              addr;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg      <= ROW_WIDTH_RESET;
            four_channels_reg  <= 1'b0;
            threshold_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_WIDTH:      row_width_reg      <= cfg_wdata[ROW_WIDTH_W-1:0];
                REG_FOUR_CHANNELS:  four_channels_reg  <= cfg_wdata[0];
                REG_THRESHOLD_MODE: threshold_mode_reg <= cfg_wdata[0];
                default:            ;
            endcase
        end
    end

    // Handshake: the input stalls only when a finished result is stuck in stage one.
    assign out_adv      = !out_valid_reg || results.ready;
    assign s1_adv       = s1_valid_reg && out_adv;
    assign pixels.ready = !s1_valid_reg || out_adv;
    assign accept       = pixels.valid && pixels.ready;

    assign px[0] = pixels.in_c0;
    assign px[1] = pixels.in_c1;
    assign px[2] = pixels.in_c2;
    assign px[3] = pixels.in_c3;

    // Effective width, clamped to the line store size.
    assign row_width_ext = WidW'(row_width_reg);
    assign eff_width     = (row_width_ext > WidW'(MAX_WIDTH)) ? WidW'(MAX_WIDTH)
                                                              : row_width_ext;

    // Position of the incoming pixel; start of frame clears it first.
    assign col_cur  = pixels.start_of_frame ? '0 : col_reg;
    assign odd_cur  = pixels.start_of_frame ? 1'b0 : odd_row_reg;
    assign col_ext  = WidW'(col_cur);
    assign col_inc  = col_ext + WidW'(1);
    assign in_row   = (col_ext < eff_width) && (eff_width >= WidW'(2));
    assign odd_col  = col_cur[0];
    assign row_done = (col_inc >= eff_width);
    assign addr     = col_cur[AddrW:1];
    assign produce  = in_row && odd_col && odd_cur;
    assign row_end  = ((col_ext >> 1) == ((eff_width >> 1) - WidW'(1)));
    assign ram_we   = accept && in_row && odd_col && !odd_cur;
    assign ram_re   = accept && produce;

    // Horizontal pair sums of the current pixel with the held even-column pixel.
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            pair[c] = PAIR_W'(first_reg[c]) + PAIR_W'(px[c]);
        end
    end

    // Next position along the row.
    always_comb
    begin
        col_next     = col_cur;
        odd_row_next = odd_cur;
        if (row_done)
        begin
            col_next     = '0;
            odd_row_next = !odd_cur;
        end
        else
        begin
            col_next = col_inc[ColW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            odd_row_reg <= 1'b0;
            first_reg   <= '0;
        end
        else if (accept)
        begin
            col_reg     <= col_next;
            odd_row_reg <= odd_row_next;
            if (in_row && !odd_col)
            begin
                first_reg <= px;
            end
        end
    end

    // Line store of pair sums from the even rows.
    bds_ram #(
        .WIDTH (WordW),
        .DEPTH (PairDepth)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (pair),
        .re    (ram_re),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    assign stored = ram_rdata;

    // Stage one: holds the odd-row pair sums while the stored sums are read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= produce;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            s1_pair_reg    <= pair;
            s1_row_end_reg <= row_end;
        end
    end

    // Block sum per channel, then average or threshold; one-channel mode zeroes the upper channels.
    always_comb
    begin
        sum_t s;
        for (int c = 0; c < NUM_CH; c++)
        begin
            s = SUM_W'(stored[c]) + SUM_W'(s1_pair_reg[c]);
            if (threshold_mode_reg)
            begin
                out_pix_next[c] = (s > THRESH_LEVEL) ? PIX_MAX : '0;
            end
            else
            begin
                out_pix_next[c] = s[SUM_W-1:2];
            end
            if ((c != 0) && !four_channels_reg)
            begin
                out_pix_next[c] = '0;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_pix_reg     <= out_pix_next;
            out_row_end_reg <= s1_row_end_reg;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.out_c0  = out_pix_reg[0];
    assign results.out_c1  = out_pix_reg[1];
    assign results.out_c2  = out_pix_reg[2];
    assign results.out_c3  = out_pix_reg[3];
    assign results.row_end = out_row_end_reg;

    // A result in stage one that cannot move on stays there.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_adv |=> s1_valid_reg)
        else $error("stage one result lost while stalled");

    // No new pixel is taken while stage one is blocked.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_adv |-> !pixels.ready)
        else $error("pixel accepted while stage one is blocked");

    // A pixel either reads or writes the line store, never both.
    a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("line store read and written by the same pixel");

    // A new result only appears after stage one held one.
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a stage one word");

endmodule : box_downsample_2x2_top

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for box_downsample_2x2_top: streams pixel words in raster order,
// predicts each 2x2 block result and checks every result word in arrival order.
// Depends on bds_pkg, the bds_pix_if and bds_res_if interfaces and the block's RTL.

module tb_top;
    import bds_pkg::*;

    localparam int MAX_W         = DEFAULT_MAX_WIDTH;
    localparam int PAIR_SLOTS    = MAX_W / 2;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int TAIL_ITEMS    = 250;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic              sof;
        pix_t [NUM_CH-1:0] ch;
    } pixel_word_t;

    typedef struct packed {
        pix_t [NUM_CH-1:0] ch;
        logic              row_end;
    } block_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    bds_pix_if pix_bus ();
    bds_res_if blk_bus ();

    box_downsample_2x2_top #(
        .MAX_WIDTH(MAX_W)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .pixels   (pix_bus),
        .results  (blk_bus)
    );

    // Free-running clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow of the configuration registers and of the block's stream state.
    logic [ROW_WIDTH_W-1:0] row_width_q = ROW_WIDTH_RESET;
    logic                   four_ch_q   = 1'b0;
    logic                   thresh_q    = 1'b0;
    pair_t                  pair_sums [PAIR_SLOTS][NUM_CH];
    pix_t [NUM_CH-1:0]      first_q     = '0;
    int unsigned            col_q       = 0;
    logic                   odd_q       = 1'b0;
    block_word_t            expected_blocks [$];

    int unsigned error_count  = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left   = 0;
    bit          gaps_on      = 1'b1;
    bit          stalls_on    = 1'b1;

    // Advances the shadow state by one accepted pixel word and queues the block
    // result that it completes, if any.
    function automatic void predict_pixel(input pixel_word_t w);
        int unsigned width;
        int unsigned col;
        int unsigned slot;
        sum_t        total;
        pix_t        level;
        block_word_t blk;
        width = (row_width_q > MAX_W) ? MAX_W : row_width_q;
        if (w.sof)
        begin
            col_q = 0;
            odd_q = 1'b0;
        end
        col  = col_q;
        slot = (col >> 1) % PAIR_SLOTS;
        if (col < width && width >= 2)
        begin
            if ((col & 1) == 0)
                first_q = w.ch;
            else if (!odd_q)
            begin
                for (int c = 0; c < NUM_CH; c++)
                    pair_sums[slot][c] = pair_t'(first_q[c]) + pair_t'(w.ch[c]);
            end
            else
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    total = sum_t'(pair_sums[slot][c]) + sum_t'(first_q[c])
                            + sum_t'(w.ch[c]);
                    if (thresh_q)
                        level = (total > THRESH_LEVEL) ? PIX_MAX : '0;
                    else
                        level = total[SUM_W-1:2];
                    if (c > 0 && !four_ch_q)
                        level = '0;
                    blk.ch[c] = level;
                end
                blk.row_end = ((col >> 1) == (width >> 1) - 1);
                expected_blocks.push_back(blk);
            end
        end
        col++;
        if (col >= width)
        begin
            col_q = 0;
            odd_q = !odd_q;
        end
        else
            col_q = col & 32'h7FF;
    endfunction

    // Bus monitor: tracks register writes, predicts from accepted pixel words and
    // checks each accepted result word against the oldest prediction.
    always @(posedge clk)
    begin : watch_bus
        pixel_word_t pw;
        block_word_t got;
        block_word_t want;
        bit          bad;
        if (!rst_n)
        begin
            row_width_q  = ROW_WIDTH_RESET;
            four_ch_q    = 1'b0;
            thresh_q     = 1'b0;
            first_q      = '0;
            col_q        = 0;
            odd_q        = 1'b0;
            quiet_cycles = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROW_WIDTH:      row_width_q = cfg_wdata[ROW_WIDTH_W-1:0];
                    REG_FOUR_CHANNELS:  four_ch_q   = cfg_wdata[0];
                    REG_THRESHOLD_MODE: thresh_q    = cfg_wdata[0];
                    default: ;
                endcase
            end

            if (pix_bus.valid && pix_bus.ready)
            begin
                pw.sof   = pix_bus.start_of_frame;
                pw.ch[0] = pix_bus.in_c0;
                pw.ch[1] = pix_bus.in_c1;
                pw.ch[2] = pix_bus.in_c2;
                pw.ch[3] = pix_bus.in_c3;
                predict_pixel(pw);
            end

            if (blk_bus.valid && blk_bus.ready)
            begin
                got.ch[0]   = blk_bus.out_c0;
                got.ch[1]   = blk_bus.out_c1;
                got.ch[2]   = blk_bus.out_c2;
                got.ch[3]   = blk_bus.out_c3;
                got.row_end = blk_bus.row_end;
                if (expected_blocks.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                    begin
                        $write("%0t: result word with none expected:", $time);
                        $display(" c0=%0d c1=%0d c2=%0d c3=%0d row_end=%0b",
                                 got.ch[0], got.ch[1], got.ch[2], got.ch[3], got.row_end);
                    end
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    bad  = (got.row_end !== want.row_end);
                    for (int c = 0; c < NUM_CH; c++)
                        if (got.ch[c] !== want.ch[c])
                            bad = 1'b1;
                    if (bad)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: mismatch: expected c0=%0d c1=%0d c2=%0d c3=%0d %s",
                                     $time, want.ch[0], want.ch[1], want.ch[2], want.ch[3],
                                     "row_end");
                            $display("    expected row_end=%0b, got c0=%0d c1=%0d c2=%0d %s",
                                     want.row_end, got.ch[0], got.ch[1], got.ch[2], "c3");
                            $display("    got c3=%0d row_end=%0b", got.ch[3], got.row_end);
                        end
                    end
                end
            end

            if ((pix_bus.valid && pix_bus.ready) || (blk_bus.valid && blk_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Result-side back-pressure: the result ready is dropped in random bursts.
    always @(negedge clk)
    begin
        if (stall_left != 0)
            stall_left--;
        else if (stalls_on && $urandom_range(0, 7) == 0)
        begin
            blk_bus.ready <= 1'b0;
            stall_left = $urandom_range(0, 5);
        end
        else
            blk_bus.ready <= 1'b1;
    end

    // Watchdog: ends the run when nothing moves on either side for too long.
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("box_downsample_2x2_top regression: fail");
        $finish;
    end

    function automatic pixel_word_t make_pixel(input logic sof, input pix_t c0, input pix_t c1,
                                               input pix_t c2, input pix_t c3);
        pixel_word_t w;
        w.sof   = sof;
        w.ch[0] = c0;
        w.ch[1] = c1;
        w.ch[2] = c2;
        w.ch[3] = c3;
        return w;
    endfunction

    // Sample value up to top, with the two ends of the range favored.
    function automatic pix_t random_sample(input int unsigned top);
        if ($urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) != 0) ? pix_t'(top) : '0;
        return pix_t'($urandom_range(0, top));
    endfunction

    // Sends one pixel word, possibly after an idle burst; called and returns at a
    // falling edge.
    task automatic send_pixel(input pixel_word_t w);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            pix_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        pix_bus.valid          <= 1'b1;
        pix_bus.start_of_frame <= w.sof;
        pix_bus.in_c0          <= w.ch[0];
        pix_bus.in_c1          <= w.ch[1];
        pix_bus.in_c2          <= w.ch[2];
        pix_bus.in_c3          <= w.ch[3];
        @(posedge clk);
        while (!pix_bus.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stops the pixel stream and waits until every predicted word has arrived
    // and the pipeline has had time to empty.
    task automatic settle();
        pix_bus.valid <= 1'b0;
        while (expected_blocks.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes all three registers while the block is idle; the mode registers
    // carry random upper bits that the block must ignore.
    task automatic configure(input int unsigned width, input logic four, input logic thresh);
        logic [CFG_DATA_W-2:0] junk;
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROW_WIDTH;
        cfg_wdata <= CFG_DATA_W'(width);
        @(negedge clk);
        junk = (CFG_DATA_W-1)'($urandom);
        cfg_index <= REG_FOUR_CHANNELS;
        cfg_wdata <= {junk, four};
        @(negedge clk);
        junk = (CFG_DATA_W-1)'($urandom);
        cfg_index <= REG_THRESHOLD_MODE;
        cfg_wdata <= {junk, thresh};
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sends rows of random pixels; a nonzero cut drops words off the end so the
    // last row is broken off.
    task automatic send_rows(input int unsigned width, input int unsigned rows, input bit fresh,
                             input int unsigned cut, input bit noisy, input int unsigned top,
                             output int unsigned count);
        int unsigned total;
        int unsigned n;
        pixel_word_t w;
        total = ((width < 2) ? 1 : width) * rows;
        total = (cut < total) ? total - cut : 1;
        for (n = 0; n < total; n++)
        begin
            w.sof = (fresh && n == 0) || (noisy && $urandom_range(0, 63) == 0);
            for (int c = 0; c < NUM_CH; c++)
                w.ch[c] = random_sample(top);
            send_pixel(w);
        end
        count = total;
    endtask

    // Full-scale and zero blocks, and sums that truncate in the divide by four.
    task automatic test_block_average();
        configure(4, 1'b1, 1'b0);
        send_pixel(make_pixel(1'b1, 8'd255, 8'd0, 8'd1, 8'd255));
        send_pixel(make_pixel(1'b0, 8'd255, 8'd0, 8'd2, 8'd255));
        send_pixel(make_pixel(1'b0, 8'd0, 8'd255, 8'd0, 8'd0));
        send_pixel(make_pixel(1'b0, 8'd0, 8'd255, 8'd0, 8'd0));
        send_pixel(make_pixel(1'b0, 8'd255, 8'd0, 8'd3, 8'd255));
        send_pixel(make_pixel(1'b0, 8'd255, 8'd0, 8'd4, 8'd254));
        send_pixel(make_pixel(1'b0, 8'd0, 8'd255, 8'd0, 8'd0));
        send_pixel(make_pixel(1'b0, 8'd0, 8'd255, 8'd0, 8'd0));
    endtask

    // Block sums of exactly 255 and 256 on either side of the threshold.
    task automatic test_threshold_boundary();
        configure(2, 1'b1, 1'b1);
        send_pixel(make_pixel(1'b1, 8'd64, 8'd64, 8'd0, 8'd255));
        send_pixel(make_pixel(1'b0, 8'd64, 8'd64, 8'd0, 8'd255));
        send_pixel(make_pixel(1'b0, 8'd64, 8'd64, 8'd0, 8'd255));
        send_pixel(make_pixel(1'b0, 8'd63, 8'd64, 8'd0, 8'd255));
    endtask

    // One-channel mode must zero the upper channels whatever comes in on them.
    task automatic test_one_channel_mode();
        configure(2, 1'b0, 1'b0);
        send_pixel(make_pixel(1'b1, 8'd200, 8'd255, 8'd170, 8'd85));
        send_pixel(make_pixel(1'b0, 8'd17, 8'd255, 8'd85, 8'd170));
        send_pixel(make_pixel(1'b0, 8'd90, 8'd255, 8'd255, 8'd1));
        send_pixel(make_pixel(1'b0, 8'd255, 8'd255, 8'd128, 8'd127));
    endtask

    // Odd width and odd row count: the last column and the trailing row drop out.
    task automatic test_odd_geometry();
        int unsigned n;
        configure(3, 1'b1, 1'b0);
        send_rows(3, 3, 1'b1, 0, 1'b0, 255, n);
    endtask

    // Widths zero and one end the row on every pixel, so no word comes out.
    task automatic test_degenerate_width();
        int unsigned n;
        configure(0, 1'b1, 1'b0);
        send_rows(0, 3, 1'b1, 0, 1'b0, 255, n);
        configure(1, 1'b0, 1'b1);
        send_rows(1, 3, 1'b1, 0, 1'b0, 255, n);
    endtask

    // One frame, or the continuation of the last one with new modes only; the
    // width changes only together with a start of frame.
    task automatic random_phase(inout int unsigned width, input bit may_continue, input bit paced,
                                output int unsigned counted);
        int unsigned pick;
        int unsigned cut;
        int unsigned n;
        bit          fresh;
        fresh = !(may_continue && $urandom_range(0, 3) == 0);
        if (fresh)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                width = $urandom_range(0, 1);
            else if (pick < 15)
                width = $urandom_range(25, 96);
            else
                width = $urandom_range(2, 24);
        end
        configure(width, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        gaps_on   = paced && ($urandom_range(0, 3) != 0);
        stalls_on = paced && ($urandom_range(0, 3) != 0);
        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, width + 1) : 0;
        send_rows(width, $urandom_range(1, 6), fresh, cut, $urandom_range(0, 2) == 0,
                  ($urandom_range(0, 2) == 0) ? 127 : 255, n);
        counted = (width >= 2) ? n : 0;
    endtask

    task automatic test_random_traffic();
        int unsigned width;
        int unsigned counted;
        int unsigned total;
        width = 2;
        total = 0;
        while (total < RANDOM_ITEMS)
        begin
            random_phase(width, total != 0, 1'b1, counted);
            total += counted;
        end
    endtask

    // Last stretch at full rate on both sides.
    task automatic test_unpaced_tail();
        int unsigned width;
        int unsigned counted;
        int unsigned total;
        width = 2;
        total = 0;
        while (total < TAIL_ITEMS)
        begin
            random_phase(width, total != 0, 1'b0, counted);
            total += counted;
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = REG_ROW_WIDTH;
        cfg_wdata              = '0;
        pix_bus.valid          = 1'b0;
        pix_bus.start_of_frame = 1'b0;
        pix_bus.in_c0          = '0;
        pix_bus.in_c1          = '0;
        pix_bus.in_c2          = '0;
        pix_bus.in_c3          = '0;
        blk_bus.ready          = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_block_average();
        test_threshold_boundary();
        test_one_channel_mode();
        test_odd_geometry();
        test_degenerate_width();
        test_random_traffic();
        test_unpaced_tail();
        settle();

        if (error_count == 0)
            $display("box_downsample_2x2_top regression: pass");
        else
            $display("box_downsample_2x2_top regression: fail");
        $finish;
    end

endmodule : tb_top
